/* sv/lrs_pkg.sv */
// shared types and constants for the line rasterizer stepper
// depends on nothing; imported by every module of the block
package lrs_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned StepBits  = CoordBits + 1;
  localparam int unsigned ErrBits   = CoordBits + 2;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic [StepBits-1:0]       step_t;
  typedef logic [CoordBits:0]        span_t;
  typedef logic signed [CoordBits:0] nspan_t;
  typedef logic signed [ErrBits-1:0] err_t;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e req_type;
    coord_t    x_start;
    coord_t    y_start;
    coord_t    x_end;
    coord_t    y_end;
  } lrs_req_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    step_t  step_index;
    logic   last_pixel;
  } lrs_pix_t;

  // classified command handed from front to back
  typedef struct packed {
    logic   is_start;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    span_t  span_x;
    nspan_t neg_span_y;
    logic   step_right;
    logic   step_down;
  } lrs_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lrs_q_status_t;

endpackage

/* sv/lrs_front.sv */
// front stage: accepts request beats, classifies them and precomputes line setup
// depends on lrs_pkg
module lrs_front
  import lrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lrs_req_t in_req_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output lrs_cmd_t cmd_o
);

  logic     valid_q, valid_d;
  lrs_cmd_t cmd_q, cmd_d;
  logic     load;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_d            = cmd_q;
    valid_d          = valid_q;
    if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d          = 1'b1;
      cmd_d.is_start   = (in_req_i.req_type == REQ_START);
      cmd_d.x0         = in_req_i.x_start;
      cmd_d.y0         = in_req_i.y_start;
      cmd_d.x1         = in_req_i.x_end;
      cmd_d.y1         = in_req_i.y_end;
      cmd_d.step_right = in_req_i.x_start < in_req_i.x_end;
      cmd_d.step_down  = in_req_i.y_start < in_req_i.y_end;
      if (in_req_i.x_end > in_req_i.x_start) begin
        cmd_d.span_x = {1'b0, in_req_i.x_end} - {1'b0, in_req_i.x_start};
      end else begin
        cmd_d.span_x = {1'b0, in_req_i.x_start} - {1'b0, in_req_i.x_end};
      end
      // negated y span, always <= 0
      if (in_req_i.y_end > in_req_i.y_start) begin
        cmd_d.neg_span_y = {1'b0, in_req_i.y_start} - {1'b0, in_req_i.y_end};
      end else begin
        cmd_d.neg_span_y = {1'b0, in_req_i.y_end} - {1'b0, in_req_i.y_start};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* sv/lrs_queue.sv */
// two-entry command queue between front and back
// depends on lrs_pkg
module lrs_queue
  import lrs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  lrs_cmd_t      push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output lrs_cmd_t      pop_cmd_o,
  output lrs_q_status_t status_o
);

  lrs_cmd_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    unique case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

endmodule

/* sv/lrs_back.sv */
// back stage: bresenham stepping state and the registered pixel output
// depends on lrs_pkg
module lrs_back
  import lrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  lrs_cmd_t cmd_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lrs_pix_t out_pix_o
);

  coord_t   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t   goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  span_t    span_x_q, span_x_d;
  nspan_t   neg_span_y_q, neg_span_y_d;
  logic     step_right_q, step_right_d, step_down_q, step_down_d;
  err_t     err_q, err_d;
  step_t    count_q, count_d;
  logic     out_valid_q, out_valid_d;
  lrs_pix_t out_pix_q, out_pix_d;

  logic                    fire, x_move, y_move, x_done, y_done;
  logic signed [ErrBits:0] e2, neg_ext, span_ext, err_sum;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  assign x_done   = (cur_x_q == goal_x_q);
  assign y_done   = (cur_y_q == goal_y_q);
  assign e2       = {err_q, 1'b0};
  assign neg_ext  = {{2{neg_span_y_q[CoordBits]}}, neg_span_y_q};
  assign span_ext = {2'b00, span_x_q};
  assign x_move   = !x_done && (e2 >= neg_ext);
  assign y_move   = !y_done && (e2 <= span_ext);

  always_comb begin
    err_sum = {err_q[ErrBits-1], err_q};
    if (x_move) begin
      err_sum = err_sum + neg_ext;
    end
    if (y_move) begin
      err_sum = err_sum + span_ext;
    end
  end

  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    goal_x_d     = goal_x_q;
    goal_y_d     = goal_y_q;
    span_x_d     = span_x_q;
    neg_span_y_d = neg_span_y_q;
    step_right_d = step_right_q;
    step_down_d  = step_down_q;
    err_d        = err_q;
    count_d      = count_q;
    if (fire) begin
      if (cmd_i.is_start) begin
        cur_x_d      = cmd_i.x0;
        cur_y_d      = cmd_i.y0;
        goal_x_d     = cmd_i.x1;
        goal_y_d     = cmd_i.y1;
        span_x_d     = cmd_i.span_x;
        neg_span_y_d = cmd_i.neg_span_y;
        step_right_d = cmd_i.step_right;
        step_down_d  = cmd_i.step_down;
        err_d        = ErrBits'({1'b0, cmd_i.span_x} + {cmd_i.neg_span_y[CoordBits],
                                                         cmd_i.neg_span_y});
        count_d      = '0;
      end else if (!(x_done && y_done)) begin
        err_d = err_sum[ErrBits-1:0];
        if (x_move) begin
          cur_x_d = step_right_q ? cur_x_q + 1'b1 : cur_x_q - 1'b1;
        end
        if (y_move) begin
          cur_y_d = step_down_q ? cur_y_q + 1'b1 : cur_y_q - 1'b1;
        end
        if (count_q != '1) begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  // output slot holds the pixel of the state just updated
  always_comb begin
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d          = 1'b1;
      out_pix_d.pixel_x    = cur_x_d;
      out_pix_d.pixel_y    = cur_y_d;
      out_pix_d.step_index = count_d;
      out_pix_d.last_pixel = (cur_x_d == goal_x_d) && (cur_y_d == goal_y_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      span_x_q     <= '0;
      neg_span_y_q <= '0;
      step_right_q <= 1'b0;
      step_down_q  <= 1'b0;
      err_q        <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      goal_x_q     <= goal_x_d;
      goal_y_q     <= goal_y_d;
      span_x_q     <= span_x_d;
      neg_span_y_q <= neg_span_y_d;
      step_right_q <= step_right_d;
      step_down_q  <= step_down_d;
      err_q        <= err_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q <= out_pix_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;

endmodule

/* sv/line_rasterizer_stepper_unit.sv */
// line rasterizer stepper: bresenham line walk over all octants, one pixel per beat
// path: a request beat is registered in front, queue and back before its pixel beat
// throughput: one beat per cycle while out_ready_i is high (combinational error update)
// reset: asynchronous, active low; clears all pipeline valids and the line state to (0,0)
// depends on lrs_pkg, lrs_front, lrs_queue, lrs_back
module line_rasterizer_stepper_unit
  import lrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lrs_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lrs_pix_t out_pix_o
);

  logic          front_valid, front_ready;
  lrs_cmd_t      front_cmd;
  logic          q_valid, q_ready;
  lrs_cmd_t      q_cmd;
  lrs_q_status_t q_status;

  lrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  lrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd),
    .status_o     (q_status)
  );

  lrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pix_o   (out_pix_o)
  );

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_valid && q_status.full |=> front_valid && $stable(front_cmd))
    else $error("front command lost while queue full");

  a_start_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready && q_cmd.is_start |=>
      out_valid_o && (out_pix_o.step_index == '0) &&
      (out_pix_o.pixel_x == $past(q_cmd.x0)) && (out_pix_o.pixel_y == $past(q_cmd.y0)))
    else $error("start command did not emit its start pixel");

endmodule

/* verif/testbench.sv */
// self-checking testbench for line_rasterizer_stepper_unit: bresenham walks in all octants
// predicts every pixel beat in a scoreboard class and compares it field by field
// depends on lrs_pkg and the line_rasterizer_stepper_unit rtl
module testbench;
  import lrs_pkg::*;

  localparam int CoordMax      = (1 << CoordBits) - 1;
  localparam int DrainCycles   = 8;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int TargetBeats   = 1500;

  class pixel_scoreboard;
    coord_t   cur_x, cur_y, goal_x, goal_y;
    span_t    span_x;
    nspan_t   neg_span_y;
    logic     step_right, step_down;
    err_t     error_term;
    step_t    step_count;
    lrs_pix_t expected_pix_q[$];
    int unsigned mismatches, checked, lines;

    function new();
      cur_x = '0; cur_y = '0; goal_x = '0; goal_y = '0;
      span_x = '0; neg_span_y = '0; error_term = '0;
      step_right = 1'b0; step_down = 1'b0; step_count = '0;
      mismatches = 0; checked = 0; lines = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // advance the line walk by one request beat and queue the pixel it yields
    function void note_req(input lrs_req_t r);
      int x0, y0, x1, y1, e2;
      lrs_pix_t p;
      if (r.req_type == REQ_START) begin
        x0 = int'(r.x_start); y0 = int'(r.y_start);
        x1 = int'(r.x_end);   y1 = int'(r.y_end);
        cur_x = r.x_start; cur_y = r.y_start;
        goal_x = r.x_end;  goal_y = r.y_end;
        span_x = span_t'((x1 > x0) ? x1 - x0 : x0 - x1);
        neg_span_y = nspan_t'((y1 > y0) ? y0 - y1 : y1 - y0);
        step_right = (x0 < x1);
        step_down = (y0 < y1);
        error_term = err_t'(int'(span_x) + int'(neg_span_y));
        step_count = '0;
        lines++;
      end else if (cur_x != goal_x || cur_y != goal_y) begin
        // both axis tests use the same doubled error
        e2 = 2 * int'(error_term);
        if (e2 >= int'(neg_span_y) && cur_x != goal_x) begin
          error_term = err_t'(int'(error_term) + int'(neg_span_y));
          cur_x = step_right ? cur_x + 1'b1 : cur_x - 1'b1;
        end
        if (e2 <= int'(span_x) && cur_y != goal_y) begin
          error_term = err_t'(int'(error_term) + int'(span_x));
          cur_y = step_down ? cur_y + 1'b1 : cur_y - 1'b1;
        end
        if (step_count != '1) step_count++;
      end
      p.pixel_x = cur_x;
      p.pixel_y = cur_y;
      p.step_index = step_count;
      p.last_pixel = (cur_x == goal_x) && (cur_y == goal_y);
      expected_pix_q.push_back(p);
    endfunction

    task check_pix(input lrs_pix_t got);
      lrs_pix_t want;
      if (expected_pix_q.size() == 0) begin
        report($sformatf("pixel beat with nothing expected: x %0d y %0d",
                         got.pixel_x, got.pixel_y));
      end else begin
        want = expected_pix_q.pop_front();
        checked++;
        if (got.pixel_x !== want.pixel_x)
          report($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
        if (got.pixel_y !== want.pixel_y)
          report($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
        if (got.step_index !== want.step_index)
          report($sformatf("step_index got %0d want %0d", got.step_index, want.step_index));
        if (got.last_pixel !== want.last_pixel)
          report($sformatf("last_pixel got %0b want %0b", got.last_pixel, want.last_pixel));
      end
    endtask

    function int pending();
      return expected_pix_q.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_ready;
  lrs_req_t req_beat = '0;
  logic     pix_valid;
  logic     pix_ready = 1'b0;
  lrs_pix_t pix_beat;

  pixel_scoreboard sb;
  bit hold_req = 1'b0;
  int burst_left = 0;
  int n_sent = 0;
  int idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  line_rasterizer_stepper_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req_beat),
    .out_valid_o (pix_valid),
    .out_ready_i (pix_ready),
    .out_pix_o   (pix_beat)
  );

  // sample both channels at the edge where the beats are taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid && req_ready) sb.note_req(req_beat);
      if (pix_valid && pix_ready) sb.check_pix(pix_beat);
      if ((req_valid && req_ready) || (pix_valid && pix_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat accepted for %0d cycles", WatchdogLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pix_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: pix_ready <= 1'b1;
          1: pix_ready <= ($urandom_range(0, 3) != 0);
          2: pix_ready <= ($urandom_range(0, 1) != 0);
          default: pix_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // sender bursts: random burst length, random gap, sometimes no gap at all
  task pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task send_beat(input lrs_req_t r);
    pace();
    req_valid <= 1'b1;
    req_beat <= r;
    do @(posedge clk_i); while (!req_ready);
    n_sent++;
  endtask

  // advance beats carry random junk in the coordinate fields
  task send_adv();
    lrs_req_t r;
    r.req_type = REQ_ADVANCE;
    r.x_start = coord_t'($urandom);
    r.y_start = coord_t'($urandom);
    r.x_end = coord_t'($urandom);
    r.y_end = coord_t'($urandom);
    send_beat(r);
  endtask

  task walk_line(input int x0, input int y0, input int x1, input int y1, input int n_adv);
    lrs_req_t r;
    r.req_type = REQ_START;
    r.x_start = coord_t'(x0);
    r.y_start = coord_t'(y0);
    r.x_end = coord_t'(x1);
    r.y_end = coord_t'(y1);
    send_beat(r);
    repeat (n_adv) send_adv();
  endtask

  task drain();
    req_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function int pick_coord();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return CoordMax;
      default: return $urandom_range(0, CoordMax);
    endcase
  endfunction

  function int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > CoordMax) return CoordMax;
    return v;
  endfunction

  initial begin : stimulus
    int kind, span, x0, y0, x1, y1, ax, ay, n_steps, n_adv;
    bit paused_once, held_once;
    paused_once = 1'b0;
    held_once = 1'b0;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // advance with no line loaded walks the single pixel at the origin
    send_adv();
    send_adv();
    // single-pixel line, then an advance past its end
    walk_line(5, 5, 5, 5, 1);
    // corner to corner both ways, and near-flat and near-steep lines at the edges
    walk_line(0, 0, CoordMax, CoordMax, 2);
    walk_line(CoordMax, CoordMax, 0, 0, 1);
    walk_line(CoordMax, 0, 0, 3, 2);
    walk_line(0, CoordMax, 2, 0, 2);
    // flat and vertical lines, running past the endpoint
    walk_line(10, 10, 13, 10, 4);
    walk_line(10, 10, 10, 7, 4);
    drain();

    while (n_sent < TargetBeats) begin
      if (!paused_once && n_sent >= 600) begin
        drain();
        paused_once = 1'b1;
      end
      if (!held_once && n_sent >= 1000) begin
        hold_req = 1'b1;
        held_once = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // short well-formed line, mostly walked to its end and a little beyond
        x0 = pick_coord();
        y0 = pick_coord();
        span = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 150) : $urandom_range(0, 12);
        ax = $urandom_range(0, span);
        ay = $urandom_range(0, span);
        x1 = clamp_coord($urandom_range(0, 1) ? x0 + ax : x0 - ax);
        y1 = clamp_coord($urandom_range(0, 1) ? y0 + ay : y0 - ay);
        ax = (x1 > x0) ? x1 - x0 : x0 - x1;
        ay = (y1 > y0) ? y1 - y0 : y0 - y1;
        n_steps = (ax > ay) ? ax : ay;
        if ($urandom_range(0, 6) == 0) begin
          n_adv = $urandom_range(0, n_steps);
        end else begin
          n_adv = n_steps + $urandom_range(0, 2);
        end
        walk_line(x0, y0, x1, y1, n_adv);
      end else if (kind < 92) begin
        // far endpoints, cut short by the next start
        walk_line($urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
                  $urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
                  $urandom_range(0, 5));
      end else begin
        repeat ($urandom_range(1, 4)) send_adv();
      end
    end

    drain();
    while (sb.pending() > 0) begin
      sb.report("pixel beat expected but never delivered");
      void'(sb.expected_pix_q.pop_front());
    end
    $display("covered %0d request beats over %0d started lines in all octants",
             n_sent, sb.lines);
    $display("%0d pixel beats checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* line_rasterizer_stepper_unit.f */
sv/lrs_pkg.sv
sv/lrs_front.sv
sv/lrs_queue.sv
sv/lrs_back.sv
sv/line_rasterizer_stepper_unit.sv
verif/testbench.sv
